FILE: hdl/bia_pkg.sv
// shared types and constants for the bitmap id allocator
`timescale 1ns / 1ps

package bia_pkg;

  localparam int WORD_BITS = 64;
  localparam int BIT_W     = 6;
  localparam int OP_W      = 2;
  localparam int ID_OUT_W  = 12;
  localparam int STAT_W    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NOP     = 2'd3
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_RANGE     = 2'd2
  } status_t;

  typedef struct packed {
    logic                 found;
    logic [BIT_W-1:0]     bit_idx;
    logic [WORD_BITS-1:0] onehot;
  } scan_res_t;

endpackage

FILE: hdl/bitmap_id_allocator_unit.sv
// top level of the bitmap first-fit id allocator
`timescale 1ns / 1ps

// First-fit id allocator over a busy map with one bit per id, held in a RAM of
// 64-bit words. An allocate walks the words from the one holding LOW_ID up to the
// one holding ID_LIMIT-1, one read issued per cycle, and the scan unit looks
// at each returned word for its lowest free bit; the first hit is set and written
// back; the single RAM read port sets that read rate. Release reads the word, then
// clears the bit and writes it back; a release out of range goes straight to the
// result and leaves the map alone. Clear writes the map to zero one word per cycle,
// and an unused opcode goes straight to the result. After reset the block sweeps
// the whole map to zero with in_stall high. One request is worked on at a time;
// the result sits in an output register so the next request can be taken while it
// waits, and a new result waits in place while the previous one is still stalled.
// Status: ok, exhausted (id 0, map unchanged), or range error on a release outside
// LOW_ID..ID_LIMIT-1 (id echoed, map unchanged). Ids are reported in 12 bits.
module bitmap_id_allocator_unit #(
  parameter int ID_LIMIT = 4096,
  parameter int LOW_ID   = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bia_pkg::OP_W-1:0]     in_opcode,
  input  logic [bia_pkg::ID_OUT_W-1:0] in_id_in,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bia_pkg::ID_OUT_W-1:0] out_id_out,
  output logic [bia_pkg::STAT_W-1:0]   out_status
);
  import bia_pkg::*;

  // map geometry
  localparam int MAP_WORDS = (ID_LIMIT + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam bit EMPTY_RANGE = (LOW_ID >= ID_LIMIT);
  localparam logic [WORD_W-1:0] FIRST_W =
    WORD_W'(EMPTY_RANGE ? 0 : LOW_ID / WORD_BITS);
  localparam logic [WORD_W-1:0] LAST_W = WORD_W'((ID_LIMIT - 1) / WORD_BITS);
  // ids below LOW_ID in the first word and at or above ID_LIMIT in the last word
  localparam logic [WORD_BITS-1:0] LO_MASK =
    (WORD_BITS'(1) << (LOW_ID % WORD_BITS)) - WORD_BITS'(1);
  localparam logic [WORD_BITS-1:0] HI_MASK =
    ~((WORD_BITS'(2) << ((ID_LIMIT - 1) % WORD_BITS)) - WORD_BITS'(1));

  typedef enum logic [2:0] {
    S_CLR,      // sweep the map to zero
    S_IDLE,     // ready for a request
    S_SCAN,     // allocate: stream words through the scan unit
    S_REL_RD,   // release: read the word
    S_REL_WR,   // release: clear the bit and write back
    S_POST      // hand result to the output register
  } state_t;

  state_t               state_r;
  logic [WORD_W-1:0]    clr_w_r;
  logic                 post_clr_r;
  logic [WORD_W-1:0]    scan_w_r;    // next word to read
  logic [WORD_W-1:0]    chk_w_r;     // word whose data is returning
  logic                 rd_pend_r;
  logic                 issue_done_r;
  logic [WORD_W-1:0]    rel_w_r;
  logic [BIT_W-1:0]     rel_b_r;
  logic [ID_OUT_W-1:0]  res_id_r;
  status_t              res_st_r;
  logic                 out_valid_r;
  logic [ID_OUT_W-1:0]  out_id_r;
  status_t              out_st_r;

  // ram port signals
  logic                 ram_we;
  logic [WORD_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [WORD_W-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // scan unit
  logic [WORD_BITS-1:0] scan_mask;
  scan_res_t            scan_res;
  logic                 hit;
  logic [WORD_W+BIT_W-1:0] alloc_full;

  // request decode
  logic                 in_acc;
  opcode_t              op;
  logic                 rel_bad;

  bia_map_ram #(
    .DEPTH (MAP_WORDS),
    .AW    (WORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    scan_mask = '0;
    if (chk_w_r == FIRST_W) begin
      scan_mask = scan_mask | LO_MASK;
    end
    if (chk_w_r == LAST_W) begin
      scan_mask = scan_mask | HI_MASK;
    end
  end

  bia_word_scan u_scan (
    .word_in (ram_rdata),
    .mask_in (scan_mask),
    .res     (scan_res)
  );

  assign hit        = (state_r == S_SCAN) && rd_pend_r && scan_res.found;
  assign alloc_full = {chk_w_r, scan_res.bit_idx};

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign op       = opcode_t'(in_opcode);
  assign rel_bad  = (32'(in_id_in) < 32'(LOW_ID)) || (32'(in_id_in) >= 32'(ID_LIMIT));

  // ram port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_w_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = scan_w_r;
    unique case (state_r)
      S_CLR: begin
        ram_we = 1'b1;
      end
      S_SCAN: begin
        ram_re    = !issue_done_r;
        ram_we    = hit;
        ram_waddr = chk_w_r;
        ram_wdata = ram_rdata | scan_res.onehot;
      end
      S_REL_RD: begin
        ram_re    = 1'b1;
        ram_raddr = rel_w_r;
      end
      S_REL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = rel_w_r;
        ram_wdata = ram_rdata & ~(WORD_BITS'(1) << rel_b_r);
      end
      S_IDLE, S_POST: begin
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_w_r      <= '0;
      post_clr_r   <= 1'b0;
      rd_pend_r    <= 1'b0;
      issue_done_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // result taken; in S_POST the output register is reloaded instead
      if (out_valid_r && !out_stall && state_r != S_POST) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          if (clr_w_r == LAST_W) begin
            state_r <= post_clr_r ? S_POST : S_IDLE;
          end else begin
            clr_w_r <= clr_w_r + WORD_W'(1);
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            unique case (op)
              OP_ALLOC: begin
                res_id_r <= '0;
                if (EMPTY_RANGE) begin
                  res_st_r <= ST_EXHAUSTED;
                  state_r  <= S_POST;
                end else begin
                  res_st_r     <= ST_OK;
                  scan_w_r     <= FIRST_W;
                  rd_pend_r    <= 1'b0;
                  issue_done_r <= 1'b0;
                  state_r      <= S_SCAN;
                end
              end
              OP_RELEASE: begin
                res_id_r <= in_id_in;
                rel_w_r  <= WORD_W'(in_id_in[ID_OUT_W-1:BIT_W]);
                rel_b_r  <= in_id_in[BIT_W-1:0];
                if (rel_bad) begin
                  res_st_r <= ST_RANGE;
                  state_r  <= S_POST;
                end else begin
                  res_st_r <= ST_OK;
                  state_r  <= S_REL_RD;
                end
              end
              OP_CLEAR: begin
                res_id_r   <= '0;
                res_st_r   <= ST_OK;
                clr_w_r    <= '0;
                post_clr_r <= 1'b1;
                state_r    <= S_CLR;
              end
              OP_NOP: begin
                res_id_r <= '0;
                res_st_r <= ST_OK;
                state_r  <= S_POST;
              end
              default: begin
                res_id_r <= '0;
                res_st_r <= ST_OK;
                state_r  <= S_POST;
              end
            endcase
          end
        end
        S_SCAN: begin
          // one read issued per cycle, data checked in the next cycle
          if (!issue_done_r) begin
            chk_w_r   <= scan_w_r;
            rd_pend_r <= 1'b1;
            if (scan_w_r == LAST_W) begin
              issue_done_r <= 1'b1;
            end else begin
              scan_w_r <= scan_w_r + WORD_W'(1);
            end
          end else begin
            rd_pend_r <= 1'b0;
          end
          if (hit) begin
            res_id_r <= ID_OUT_W'(alloc_full);
            state_r  <= S_POST;
          end else if (rd_pend_r && chk_w_r == LAST_W) begin
            res_st_r <= ST_EXHAUSTED;
            state_r  <= S_POST;
          end
        end
        S_REL_RD: begin
          state_r <= S_REL_WR;
        end
        S_REL_WR: begin
          state_r <= S_POST;
        end
        S_POST: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_id_r    <= res_id_r;
            out_st_r    <= res_st_r;
            post_clr_r  <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_id_out = out_id_r;
  assign out_status = out_st_r;

endmodule

FILE: hdl/bia_map_ram.sv
// busy map storage, one write port and one registered read port
`timescale 1ns / 1ps

module bia_map_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [bia_pkg::WORD_BITS-1:0] wdata,
  input  logic                          re,
  input  logic [AW-1:0]                 raddr,
  output logic [bia_pkg::WORD_BITS-1:0] rdata
);
  import bia_pkg::*;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/bia_word_scan.sv
// find-first-free unit over one map word
`timescale 1ns / 1ps

module bia_word_scan (
  input  logic [bia_pkg::WORD_BITS-1:0] word_in,
  input  logic [bia_pkg::WORD_BITS-1:0] mask_in,
  output bia_pkg::scan_res_t            res
);
  import bia_pkg::*;

  logic [WORD_BITS-1:0] eff;
  logic [WORD_BITS-1:0] sel;
  logic [BIT_W-1:0]     idx;

  // masked bits count as busy; lowest zero isolated by the carry of +1
  assign eff = word_in | mask_in;
  assign sel = ~eff & (eff + WORD_BITS'(1));

  always_comb begin
    idx = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (sel[b]) begin
        idx = idx | BIT_W'(b);
      end
    end
  end

  assign res.found   = ~&eff;
  assign res.bit_idx = idx;
  assign res.onehot  = sel;

endmodule

FILE: hdl/bia_checker.sv
// port-level checks for the id allocator, bound to the top level
`timescale 1ns / 1ps

module bia_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [bia_pkg::ID_OUT_W-1:0] out_id_out,
  input logic [bia_pkg::STAT_W-1:0]   out_status
);
  import bia_pkg::*;

  // a held result keeps its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_id_out) && $stable(out_status))
    else $error("result changed while stalled");

  // an accepted request leaves the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted back to back");

  // reset starts the map sweep with nothing to deliver
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("not busy after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_EXHAUSTED ||
                   out_status == ST_RANGE))
    else $error("unused status code");

  a_exhausted_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EXHAUSTED |-> out_id_out == '0)
    else $error("exhausted result carries an id");

endmodule

bind bitmap_id_allocator_unit bia_checker u_bia_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_id_out (out_id_out),
  .out_status (out_status)
);
